// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ACC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, no reset qualifier.
`define ACC_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/acc_pkg.sv -----
// Package: pipeline stage record, schedule constants and per-stage logic.
`default_nettype none
package acc_pkg;

   localparam int unsigned COORD_BITS  = 24;
   localparam int unsigned RAD_BITS    = COORD_BITS - 1;
   localparam int unsigned HALF_BITS   = COORD_BITS - 2;
   localparam int unsigned NORM_BITS   = 16;

   localparam int unsigned ST_SQRT0    = 6;
   localparam int unsigned ST_ROUND    = 19;
   localparam int unsigned ST_DIV0     = 20;
   localparam int unsigned ST_OUT      = 35;
   localparam int unsigned NUM_STAGES  = 36;

   localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] COORD_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [23:0] bx;
      logic signed [23:0] by;
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic [21:0]        hw;
      logic [21:0]        hh;
      logic [22:0]        r;
      logic signed [24:0] rx;
      logic signed [24:0] ry;
      logic [23:0]        px;
      logic [23:0]        py;
      logic signed [23:0] cont_x;
      logic signed [23:0] cont_y;
      logic [23:0]        dx;
      logic [23:0]        dy;
      logic               hit;
      logic               neg_x;
      logic               neg_y;
      logic               zero_dir;
      logic [24:0]        ax;
      logic [24:0]        ay;
      logic [49:0]        sqx;
      logic [49:0]        sqy;
      logic [45:0]        r2;
      logic [51:0]        n_d;
      logic [51:0]        n_l;
      logic [27:0]        rem_d;
      logic [27:0]        rem_l;
      logic [25:0]        root_d;
      logic [25:0]        root_l;
      logic [22:0]        pen;
      logic [39:0]        num_x;
      logic [39:0]        num_y;
      logic [39:0]        dvs;
      logic [14:0]        q_x;
      logic [14:0]        q_y;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
   } pipe_type;

   typedef struct packed {
      logic [51:0] n;
      logic [27:0] rem;
      logic [25:0] root;
   } sqrt_type;

   // one digit of the restoring square root
   function automatic sqrt_type sqrt_iter(input sqrt_type a);
      sqrt_type    b;
      logic [29:0] t;
      logic [29:0] trial;
      b     = a;
      t     = {a.rem, a.n[51:50]};
      trial = {2'b00, a.root, 2'b01};
      if (t >= trial) begin
         b.rem  = 28'(t - trial);
         b.root = {a.root[24:0], 1'b1};
      end else begin
         b.rem  = t[27:0];
         b.root = {a.root[24:0], 1'b0};
      end
      b.n = {a.n[49:0], 2'b00};
      return b;
   endfunction

   function automatic pipe_type stage_fn(input int unsigned k, input pipe_type x);
      pipe_type           y;
      logic [23:0]        sz_x;
      logic [23:0]        sz_y;
      logic signed [25:0] sum;
      logic signed [25:0] diff;
      logic [24:0]        o;
      logic [24:0]        a_x;
      logic [24:0]        a_y;
      sqrt_type           sd;
      sqrt_type           sl;
      logic [26:0]        s;
      y = x;
      if (k == 0) begin
         y.rx = $signed({x.cx[23], x.cx}) - $signed({x.bx[23], x.bx});
         y.ry = $signed({x.cy[23], x.cy}) - $signed({x.by[23], x.by});
         sz_x = {1'b0, x.hw, 1'b0};
         sz_y = {1'b0, x.hh, 1'b0};
         if (y.rx > $signed({1'b0, sz_x}))  y.px = sz_x;
         else if (y.rx < 0)                 y.px = '0;
         else                               y.px = y.rx[23:0];
         if (y.ry > $signed({1'b0, sz_y}))  y.py = sz_y;
         else if (y.ry < 0)                 y.py = '0;
         else                               y.py = y.ry[23:0];
         sum = $signed({{2{x.bx[23]}}, x.bx}) + $signed({2'b00, y.px});
         if (sum > 26'(COORD_MAX))      y.cont_x = COORD_MAX;
         else if (sum < 26'(COORD_MIN)) y.cont_x = COORD_MIN;
         else                           y.cont_x = sum[23:0];
         sum = $signed({{2{x.by[23]}}, x.by}) + $signed({2'b00, y.py});
         if (sum > 26'(COORD_MAX))      y.cont_y = COORD_MAX;
         else if (sum < 26'(COORD_MIN)) y.cont_y = COORD_MIN;
         else                           y.cont_y = sum[23:0];
      end else if (k == 1) begin
         diff = $signed({x.rx[24], x.rx}) - $signed({2'b00, x.px});
         y.dx = (diff < 0) ? 24'(-diff) : diff[23:0];
         diff = $signed({x.ry[24], x.ry}) - $signed({2'b00, x.py});
         y.dy = (diff < 0) ? 24'(-diff) : diff[23:0];
         y.hit   = !((y.dx > {1'b0, x.r}) || (y.dy > {1'b0, x.r}));
         y.neg_x = x.rx < 0;
         y.neg_y = x.ry < 0;
         y.ax    = y.neg_x ? 25'(-x.rx) : x.rx;
         y.ay    = y.neg_y ? 25'(-x.ry) : x.ry;
         y.zero_dir = (y.ax == '0) && (y.ay == '0);
      end else if (k == 2) begin
         y.sqx = 50'(x.dx) * 50'(x.dx);
         y.sqy = 50'(x.dy) * 50'(x.dy);
         y.r2  = 46'(x.r) * 46'(x.r);
         a_x = x.ax;
         a_y = x.ay;
         o = a_x | a_y;
         if (o[24:9] == '0) begin
            a_x = a_x << 16;
            a_y = a_y << 16;
         end
         o = a_x | a_y;
         if (o[24:17] == '0) begin
            a_x = a_x << 8;
            a_y = a_y << 8;
         end
         y.ax = a_x;
         y.ay = a_y;
      end else if (k == 3) begin
         y.n_d = 52'(x.sqx) + 52'(x.sqy);
         if (y.n_d > 52'(x.r2)) y.hit = 1'b0;
         a_x = x.ax;
         a_y = x.ay;
         o = a_x | a_y;
         if (o[24:21] == '0) begin
            a_x = a_x << 4;
            a_y = a_y << 4;
         end
         o = a_x | a_y;
         if (o[24:23] == '0) begin
            a_x = a_x << 2;
            a_y = a_y << 2;
         end
         o = a_x | a_y;
         if (!o[24]) begin
            a_x = a_x << 1;
            a_y = a_y << 1;
         end
         y.ax = a_x;
         y.ay = a_y;
      end else if (k == 4) begin
         y.sqx = 50'(x.ax) * 50'(x.ax);
         y.sqy = 50'(x.ay) * 50'(x.ay);
      end else if (k == 5) begin
         y.n_l    = 52'(x.sqx) + 52'(x.sqy);
         y.rem_d  = '0;
         y.rem_l  = '0;
         y.root_d = '0;
         y.root_l = '0;
      end else if (k >= ST_SQRT0 && k < ST_ROUND) begin
         sd = sqrt_iter(sqrt_iter('{n: x.n_d, rem: x.rem_d, root: x.root_d}));
         sl = sqrt_iter(sqrt_iter('{n: x.n_l, rem: x.rem_l, root: x.root_l}));
         y.n_d = sd.n;  y.rem_d = sd.rem;  y.root_d = sd.root;
         y.n_l = sl.n;  y.rem_l = sl.rem;  y.root_l = sl.root;
      end else if (k == ST_ROUND) begin
         s = 27'(x.root_d) + 27'(x.rem_d > 28'(x.root_d));
         y.pen   = x.r - s[22:0];
         y.num_x = (40'(x.ax) << 14) + 40'(x.root_l >> 1);
         y.num_y = (40'(x.ay) << 14) + 40'(x.root_l >> 1);
         y.dvs   = {x.root_l, 14'b0};
         y.q_x   = '0;
         y.q_y   = '0;
      end else if (k >= ST_DIV0 && k < ST_OUT) begin
         if (x.num_x >= x.dvs) begin
            y.num_x = x.num_x - x.dvs;
            y.q_x   = {x.q_x[13:0], 1'b1};
         end else begin
            y.q_x   = {x.q_x[13:0], 1'b0};
         end
         if (x.num_y >= x.dvs) begin
            y.num_y = x.num_y - x.dvs;
            y.q_y   = {x.q_y[13:0], 1'b1};
         end else begin
            y.q_y   = {x.q_y[13:0], 1'b0};
         end
         y.dvs = x.dvs >> 1;
      end else if (k == ST_OUT) begin
         y.nx = x.neg_x ? -$signed({1'b0, x.q_x}) : $signed({1'b0, x.q_x});
         y.ny = x.neg_y ? -$signed({1'b0, x.q_y}) : $signed({1'b0, x.q_y});
         if (!x.hit || x.zero_dir) begin
            y.nx = '0;
            y.ny = '0;
         end
         if (!x.hit) begin
            y.pen    = '0;
            y.cont_x = '0;
            y.cont_y = '0;
         end
      end
      return y;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/aabb_circle_contact.sv -----
// Top level: pipelined box / circle contact test.
//
// Usage
//  - Request channel req_*: one box (lower corner, half extents) and one
//    circle (centre, radius) per transaction, valid/ready handshake.
//  - Response channel rsp_*: hit flag, penetration, unit normal (Q1.14) and
//    contact point per transaction, in request order, valid/ready handshake.
//  - Pipeline: 36 register stages; a result is offered from the last stage.
//  - Throughput: one transaction per cycle while req_ready is high. The
//    two square roots (one for the distance, one for the normal length)
//    take two digits per stage over 13 stages, the normal divide one
//    quotient bit per stage over 15 stages.
//  - Stall: when rsp_ready is low the last stage holds; upstream stages keep
//    advancing into empty slots, so req_ready only falls once every stage
//    holds a transaction.
//  - Reset (synchronous, active high) empties the pipeline; payload is
//    not cleared.
`default_nettype none
module aabb_circle_contact
   import acc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [23:0]   req_box_x,
   input  wire logic signed [23:0]   req_box_y,
   input  wire logic [21:0]          req_box_half_w,
   input  wire logic [21:0]          req_box_half_h,
   input  wire logic signed [23:0]   req_circle_x,
   input  wire logic signed [23:0]   req_circle_y,
   input  wire logic [22:0]          req_circle_radius,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_hit,
   output logic [22:0]               rsp_penetration,
   output logic signed [15:0]        rsp_normal_x,
   output logic signed [15:0]        rsp_normal_y,
   output logic signed [23:0]        rsp_contact_x,
   output logic signed [23:0]        rsp_contact_y
);

   pipe_type                entry;
   pipe_type                pipe_ff [NUM_STAGES];
   pipe_type                pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   vld_ff;
   logic [NUM_STAGES-1:0]   adv;

   // raw request into the stage record
   always_comb begin
      entry    = '0;
      entry.bx = req_box_x;
      entry.by = req_box_y;
      entry.hw = req_box_half_w;
      entry.hh = req_box_half_h;
      entry.cx = req_circle_x;
      entry.cy = req_circle_y;
      entry.r  = req_circle_radius;
   end

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      // a stage moves when any slot at or below it is free, or the sink takes
      assign adv[g] = rsp_ready | ~(&vld_ff[NUM_STAGES-1:g]);

      if (g == 0) begin : g_first
         assign pipe_in[g] = stage_fn(g, entry);
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g] <= 1'b0;
            end else if (adv[g]) begin
               vld_ff[g] <= req_valid;
            end
         end
      end else begin : g_next
         assign pipe_in[g] = stage_fn(g, pipe_ff[g-1]);
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g] <= 1'b0;
            end else if (adv[g]) begin
               vld_ff[g] <= vld_ff[g-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv[g]) begin
            pipe_ff[g] <= pipe_in[g];
         end
      end
   end

   assign req_ready       = adv[0];
   assign rsp_valid       = vld_ff[NUM_STAGES-1];
   assign rsp_hit         = pipe_ff[NUM_STAGES-1].hit;
   assign rsp_penetration = pipe_ff[NUM_STAGES-1].pen;
   assign rsp_normal_x    = pipe_ff[NUM_STAGES-1].nx;
   assign rsp_normal_y    = pipe_ff[NUM_STAGES-1].ny;
   assign rsp_contact_x   = pipe_ff[NUM_STAGES-1].cont_x;
   assign rsp_contact_y   = pipe_ff[NUM_STAGES-1].cont_y;

endmodule
`default_nettype wire

// ----- rtl/acc_checker.sv -----
// Port-level checker for the contact block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module acc_checker
   import acc_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_hit,
   input wire logic [22:0]          rsp_penetration,
   input wire logic signed [15:0]   rsp_normal_x,
   input wire logic signed [15:0]   rsp_normal_y,
   input wire logic signed [23:0]   rsp_contact_x,
   input wire logic signed [23:0]   rsp_contact_y
);

   logic miss_zero;
   logic norm_ok;
   logic rsp_stall;
   logic [RAD_BITS-1:0] pen_w;
   logic [103:0]        rsp_key;

   assign pen_w     = rsp_penetration;
   assign miss_zero = (pen_w == '0) && (rsp_normal_x == '0) && (rsp_normal_y == '0)
                      && (rsp_contact_x == '0) && (rsp_contact_y == '0);
   assign norm_ok   = (rsp_normal_x <= 16'sd16384) && (rsp_normal_x >= -16'sd16384)
                      && (rsp_normal_y <= 16'sd16384) && (rsp_normal_y >= -16'sd16384);
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_key   = {rsp_hit, rsp_penetration, rsp_normal_x, rsp_normal_y,
                       rsp_contact_x, rsp_contact_y};

   `ACC_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, miss_zero)
   `ACC_ASSERT_IMP(a_norm_range, clock, reset, rsp_valid, norm_ok)
   `ACC_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)
   `ACC_ASSERT_IMP(a_rsp_hold, clock, reset, rsp_stall, ##1 (rsp_valid && $stable(rsp_key)))

endmodule

bind aabb_circle_contact acc_checker u_acc_checker (.*);
`default_nettype wire
